[rtl/hrmm_pkg.sv]
`default_nettype none

package hrmm_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_MISMATCH = 2'd2
    } status_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Z        = 2'd3;

    // field widths
    localparam int SIDE_W   = 11;
    localparam int HEIGHT_W = 16;
    localparam int COUNT_W  = 21;
    localparam int SUM_W    = 36;
    localparam int MEAN_W   = 24;
    localparam int SCALE_W  = 32;
    localparam int Z_W      = 48;

    // largest legal region side
    localparam logic [SIDE_W-1:0] MAX_SIDE = 11'd1024;

    // saturation limits
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [Z_W-1:0]     Z_MAX     = {1'b0, {(Z_W-1){1'b1}}};
    localparam logic [Z_W-1:0]     Z_MIN     = {1'b1, {(Z_W-1){1'b0}}};

    // reset values
    localparam logic [HEIGHT_W-1:0] MIN_INIT   = '1;
    localparam logic [SCALE_W-1:0]  SCALE_INIT = 32'd65536;

    // the mean quotient fits in MEAN_W bits, so only that many divide steps
    localparam int DIV_STEPS = MEAN_W;

    // fraction bits dropped after the scale multiply
    localparam int Z_SHIFT = 15;

endpackage

`default_nettype wire

[rtl/height_region_min_max_mean_unit.sv]
`default_nettype none

// channel   direction  signals                                   beat
// in        sink       in_valid/in_ready, height, end_of_region  one height sample
// out       source     out_valid/out_ready, status .. mean_z     one region result
// cfg       sink       cfg_valid/cfg_ready, cfg_index, cfg_data  one register write
//
// samples are taken one per cycle while accumulating; the last sample of a
// region starts a sequence of a status step, 24 restoring divide steps and
// three passes through the shared scale multiplier and saturating adder,
// then a load of the output register.
// error results skip the divide and multiply.
// reset sets the accumulators, configuration registers, sequencer and out_valid.
// a waiting result holds the sequencer in the final load, and intake stays
// closed until the output register frees.

module height_region_min_max_mean_unit
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,

    input  wire logic                                   in_valid,
    output      logic                                   in_ready,
    input  wire logic [hrmm_pkg::HEIGHT_W-1:0]          height,
    input  wire logic                                   end_of_region,

    output      logic                                   out_valid,
    input  wire logic                                   out_ready,
    output      hrmm_pkg::status_t                      status,
    output      logic [hrmm_pkg::COUNT_W-1:0]           sample_count,
    output      logic [hrmm_pkg::HEIGHT_W-1:0]          min_height,
    output      logic [hrmm_pkg::HEIGHT_W-1:0]          max_height,
    output      logic [hrmm_pkg::MEAN_W-1:0]            mean_height,
    output      logic signed [hrmm_pkg::Z_W-1:0]        min_z,
    output      logic signed [hrmm_pkg::Z_W-1:0]        max_z,
    output      logic signed [hrmm_pkg::Z_W-1:0]        mean_z,

    input  wire logic                                   cfg_valid,
    output      logic                                   cfg_ready,
    input  wire logic [hrmm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [hrmm_pkg::Z_W-1:0]               cfg_data
);

    import hrmm_pkg::*;

    typedef enum logic [2:0] {
        S_ACC,
        S_STAT,
        S_DIV,
        S_MUL,
        S_ADD,
        S_DONE
    } state_t;

    localparam int ITER_W = $clog2(DIV_STEPS);
    localparam int PROD_W = MEAN_W + SCALE_W;

    // configuration registers
    logic [SIDE_W-1:0]         region_width_reg;
    logic [SIDE_W-1:0]         region_height_reg;
    logic signed [SCALE_W-1:0] scale_z_reg;
    logic signed [Z_W-1:0]     base_z_reg;

    // running accumulators
    logic [HEIGHT_W-1:0] run_min_reg;
    logic [HEIGHT_W-1:0] run_max_reg;
    logic [SUM_W-1:0]    run_sum_reg;
    logic [COUNT_W-1:0]  run_cnt_reg;

    // snapshot of the finished region
    logic [HEIGHT_W-1:0] snap_min_reg;
    logic [HEIGHT_W-1:0] snap_max_reg;
    logic [SUM_W-1:0]    snap_sum_reg;
    logic [COUNT_W-1:0]  snap_cnt_reg;

    // divider and multiplier working registers
    logic [COUNT_W-1:0]       rem_reg;
    logic [MEAN_W-1:0]        quo_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic [1:0]               zidx_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [Z_W-1:0]    zmin_reg;
    logic signed [Z_W-1:0]    zmax_reg;
    logic signed [Z_W-1:0]    zmean_reg;
    status_t                  stat_reg;

    // fsm and output registers
    state_t                state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    status_t               status_reg, status_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [HEIGHT_W-1:0]   min_out_reg, min_out_next;
    logic [HEIGHT_W-1:0]   max_out_reg, max_out_next;
    logic [MEAN_W-1:0]     mean_out_reg, mean_out_next;
    logic signed [Z_W-1:0] min_z_reg, min_z_next;
    logic signed [Z_W-1:0] max_z_reg, max_z_next;
    logic signed [Z_W-1:0] mean_z_reg, mean_z_next;

    logic                       in_beat;
    logic                       load_out;
    logic [HEIGHT_W-1:0]        min_upd;
    logic [HEIGHT_W-1:0]        max_upd;
    logic [SUM_W:0]             sum_add;
    logic [SUM_W-1:0]           sum_upd;
    logic [COUNT_W-1:0]         cnt_upd;
    logic [2*SIDE_W-1:0]        area;
    status_t                    stat_calc;
    logic [COUNT_W:0]           trial;
    logic                       trial_ge;
    logic [MEAN_W-1:0]          hq8;
    logic signed [MEAN_W-1:0]   mul_a;
    logic signed [Z_W:0]        z_sum;
    logic signed [Z_W-1:0]      z_sat;

    assign in_ready  = (state_reg == S_ACC);
    assign in_beat   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_width_reg  <= '0;
            region_height_reg <= '0;
            scale_z_reg       <= SCALE_INIT;
            base_z_reg        <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_REGION_WIDTH:  region_width_reg  <= cfg_data[SIDE_W-1:0];
                REG_REGION_HEIGHT: region_height_reg <= cfg_data[SIDE_W-1:0];
                REG_SCALE_Z:       scale_z_reg       <= cfg_data[SCALE_W-1:0];
                REG_BASE_Z:        base_z_reg        <= cfg_data;
                default:           ;
            endcase
        end
    end

    // accumulator update for one sample
    always_comb
    begin
        min_upd = (height < run_min_reg) ? height : run_min_reg;
        max_upd = (height > run_max_reg) ? height : run_max_reg;
        sum_add = {1'b0, run_sum_reg} + (SUM_W+1)'(height);
        sum_upd = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        cnt_upd = (run_cnt_reg == COUNT_MAX) ? run_cnt_reg : run_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_reg <= MIN_INIT;
            run_max_reg <= '0;
            run_sum_reg <= '0;
            run_cnt_reg <= '0;
        end
        else if (in_beat)
        begin
            if (end_of_region)
            begin
                run_min_reg <= MIN_INIT;
                run_max_reg <= '0;
                run_sum_reg <= '0;
                run_cnt_reg <= '0;
            end
            else
            begin
                run_min_reg <= min_upd;
                run_max_reg <= max_upd;
                run_sum_reg <= sum_upd;
                run_cnt_reg <= cnt_upd;
            end
        end
    end

    // region status from the snapshot
    always_comb
    begin
        area = (2*SIDE_W)'(region_width_reg) * (2*SIDE_W)'(region_height_reg);
        if (region_width_reg == '0 || region_height_reg == '0)
            stat_calc = ST_EMPTY;
        else if (snap_cnt_reg == COUNT_MAX || snap_sum_reg == SUM_MAX ||
                 region_width_reg > MAX_SIDE || region_height_reg > MAX_SIDE ||
                 COUNT_W'(area) != snap_cnt_reg)
            stat_calc = ST_MISMATCH;
        else
            stat_calc = ST_OK;
    end

    // restoring divide step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[MEAN_W-1]};
        trial_ge = (trial >= {1'b0, snap_cnt_reg});
    end

    // shared multiplier operand: height in q.8 minus midpoint
    always_comb
    begin
        case (zidx_reg)
            2'd0:    hq8 = {snap_min_reg, 8'd0};
            2'd1:    hq8 = {snap_max_reg, 8'd0};
            default: hq8 = quo_reg;
        endcase
        mul_a = {~hq8[MEAN_W-1], hq8[MEAN_W-2:0]};
    end

    // floor shift, add base, saturate to the z range
    always_comb
    begin
        z_sum = {{(Z_W+1-(PROD_W-Z_SHIFT)){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:Z_SHIFT]}
              + {base_z_reg[Z_W-1], base_z_reg};
        if (z_sum[Z_W] != z_sum[Z_W-1])
            z_sat = z_sum[Z_W] ? Z_MIN : Z_MAX;
        else
            z_sat = z_sum[Z_W-1:0];
    end

    // datapath working registers
    always_ff @(posedge clk)
    begin
        if (in_beat && end_of_region)
        begin
            snap_min_reg <= min_upd;
            snap_max_reg <= max_upd;
            snap_sum_reg <= sum_upd;
            snap_cnt_reg <= cnt_upd;
        end
        case (state_reg)
            S_STAT:
            begin
                stat_reg <= stat_calc;
                rem_reg  <= COUNT_W'(snap_sum_reg[SUM_W-1:SUM_W-(SUM_W+8-MEAN_W)]);
                quo_reg  <= {snap_sum_reg[MEAN_W-9:0], 8'd0};
                iter_reg <= '0;
                zidx_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg  <= trial_ge ? COUNT_W'(trial - {1'b0, snap_cnt_reg})
                                     : trial[COUNT_W-1:0];
                quo_reg  <= {quo_reg[MEAN_W-2:0], trial_ge};
                iter_reg <= iter_reg + 1'b1;
            end
            S_MUL:
            begin
                prod_reg <= PROD_W'(mul_a) * PROD_W'(scale_z_reg);
            end
            S_ADD:
            begin
                case (zidx_reg)
                    2'd0:    zmin_reg  <= z_sat;
                    2'd1:    zmax_reg  <= z_sat;
                    default: zmean_reg <= z_sat;
                endcase
                zidx_reg <= zidx_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // sequencer and output register
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        min_out_next   = min_out_reg;
        max_out_next   = max_out_reg;
        mean_out_next  = mean_out_reg;
        min_z_next     = min_z_reg;
        max_z_next     = max_z_reg;
        mean_z_next    = mean_z_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_ACC:
            begin
                if (in_beat && end_of_region)
                    state_next = S_STAT;
            end
            S_STAT:
            begin
                state_next = (stat_calc == ST_OK) ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (iter_reg == ITER_W'(DIV_STEPS - 1))
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = (zidx_reg == 2'd2) ? S_DONE : S_MUL;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next     = S_ACC;
                    out_valid_next = 1'b1;
                    status_next    = stat_reg;
                    count_next     = snap_cnt_reg;
                    if (stat_reg == ST_OK)
                    begin
                        min_out_next  = snap_min_reg;
                        max_out_next  = snap_max_reg;
                        mean_out_next = quo_reg;
                        min_z_next    = zmin_reg;
                        max_z_next    = zmax_reg;
                        mean_z_next   = zmean_reg;
                    end
                    else
                    begin
                        min_out_next  = '0;
                        max_out_next  = '0;
                        mean_out_next = '0;
                        min_z_next    = '0;
                        max_z_next    = '0;
                        mean_z_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        count_reg    <= count_next;
        min_out_reg  <= min_out_next;
        max_out_reg  <= max_out_next;
        mean_out_reg <= mean_out_next;
        min_z_reg    <= min_z_next;
        max_z_reg    <= max_z_next;
        mean_z_reg   <= mean_z_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign sample_count = count_reg;
    assign min_height   = min_out_reg;
    assign max_height   = max_out_reg;
    assign mean_height  = mean_out_reg;
    assign min_z        = min_z_reg;
    assign max_z        = max_z_reg;
    assign mean_z       = mean_z_reg;

`ifndef NO_ASSERTIONS
    // last sample of a region stops intake for the result sequence
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && end_of_region |=> !in_ready)
        else $error("intake not stopped after last sample");

    // partial remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < snap_cnt_reg)
        else $error("divide remainder out of range");

    // running min never above running max once a sample is in
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        run_cnt_reg != '0 |-> run_min_reg <= run_max_reg)
        else $error("running min above running max");

    // a good result has its mean between min and max
    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_OK |->
            mean_out_reg >= {min_out_reg, 8'd0} && mean_out_reg <= {max_out_reg, 8'd0})
        else $error("mean outside min and max");

    // an error result carries zero statistics
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |->
            min_out_reg == '0 && max_out_reg == '0 && mean_out_reg == '0 &&
            min_z_reg == '0 && max_z_reg == '0 && mean_z_reg == '0)
        else $error("error result with nonzero fields");
`endif

endmodule

`default_nettype wire
